/* hw/rtl/pffc_pkg.sv */
// ----------------------------------------------------------------------------
// pffc_pkg
// Shared constants and types of the packet field frequency counter.
// ----------------------------------------------------------------------------
`default_nettype none
package pffc_pkg;
	localparam int BUCKETS       = 1024;
	localparam int WAYS          = 4;
	localparam int MAX_KEY_BYTES = 32;

	localparam int KEY_WORDS = (MAX_KEY_BYTES + 7) / 8;
	localparam int IP_BUF    = 80 + MAX_KEY_BYTES;
	localparam int BUCKET_W  = $clog2(BUCKETS);
	localparam int ENT_W     = $clog2(BUCKETS * WAYS);
	localparam int KADDR_W   = (BUCKETS * WAYS * KEY_WORDS > 1) ?
		$clog2(BUCKETS * WAYS * KEY_WORDS) : 1;
	localparam int WIN_AW    = $clog2(IP_BUF);
	localparam int LEN_W     = $clog2(MAX_KEY_BYTES + 1);
	localparam int CAP_IW    = $clog2(MAX_KEY_BYTES);
	localparam int WAY_CW    = $clog2(WAYS + 1);
	localparam int KW_CW     = $clog2(KEY_WORDS + 1);
	localparam int KW_IW     = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
	localparam int CAP_W     = KEY_WORDS * 64;

	localparam logic [1:0] ST_EXIST = 2'd0;
	localparam logic [1:0] ST_NEW   = 2'd1;
	localparam logic [1:0] ST_SHORT = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	localparam logic [2:0] MODE_PAYLOAD  = 3'd0;
	localparam logic [2:0] MODE_SRC_PORT = 3'd1;
	localparam logic [2:0] MODE_DST_PORT = 3'd2;
	localparam logic [2:0] MODE_IP_ID    = 3'd3;
	localparam logic [2:0] MODE_SEQ      = 3'd4;
	localparam logic [2:0] MODE_SRC_HOST = 3'd5;
	localparam logic [2:0] MODE_CHECKSUM = 3'd6;
	localparam logic [2:0] MODE_UNUSED   = 3'd7;

	localparam logic [7:0] PROTO_ICMP = 8'h01;
	localparam logic [7:0] PROTO_TCP  = 8'h06;
	localparam logic [7:0] PROTO_UDP  = 8'h11;
	localparam logic [7:0] PROTO_ESP  = 8'h32;
	localparam logic [7:0] PROTO_IGMP = 8'h02;

	localparam logic REG_FIELD_MODE = 1'b0;
	localparam logic REG_KEY_LENGTH = 1'b1;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] occurrence_count;
		logic [9:0]  bucket_index;
	} out_t;

	typedef struct packed {
		logic [15:0] received;
		logic [5:0]  hl;
		logic [7:0]  proto;
		logic [15:0] total_len;
	} hdr_t;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_CALC, S_KADDR, S_KDATA, S_HASH, S_VADDR, S_VDATA,
		S_WAY, S_CADDR, S_CDATA, S_NADDR, S_NDATA, S_MISS, S_INS, S_DONE
	} state_t;
endpackage
`default_nettype wire

/* hw/rtl/pffc_ram.sv */
// ----------------------------------------------------------------------------
// pffc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module pffc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/pffc_hdr.sv */
// ----------------------------------------------------------------------------
// pffc_hdr
// Frame byte tracker: IP header fields and the IP byte window.
// ----------------------------------------------------------------------------
`default_nettype none
module pffc_hdr
	import pffc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        frame_byte,
	input  wire logic              clear,
	input  wire logic [WIN_AW-1:0] win_raddr,
	output logic      [7:0]        win_rdata,
	output hdr_t                   hdr
);
	logic [15:0] bp_q;
	logic [5:0]  hl_q;
	logic [7:0]  proto_q;
	logic [15:0] tl_q;
	logic [15:0] p;
	logic        in_ip;
	logic        win_we;

	assign p      = bp_q - 16'd14;
	assign in_ip  = bp_q >= 16'd14;
	assign win_we = accept && in_ip && (p < 16'(IP_BUF));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_q    <= '0;
			hl_q    <= '0;
			proto_q <= '0;
			tl_q    <= '0;
		end else if (clear) begin
			bp_q    <= '0;
			hl_q    <= '0;
			proto_q <= '0;
			tl_q    <= '0;
		end else if (accept) begin
			if (in_ip) begin
				if (p == 16'd0)
					hl_q <= {frame_byte[3:0], 2'b00};
				else if (p == 16'd2)
					tl_q[15:8] <= frame_byte;
				else if (p == 16'd3)
					tl_q[7:0] <= frame_byte;
				else if (p == 16'd9)
					proto_q <= frame_byte;
			end
			if (bp_q != 16'hFFFF)
				bp_q <= bp_q + 16'd1;
		end
	end

	assign hdr.received  = (bp_q > 16'd14) ? bp_q - 16'd14 : 16'd0;
	assign hdr.hl        = hl_q;
	assign hdr.proto     = proto_q;
	assign hdr.total_len = tl_q;

	pffc_ram #(.WIDTH(8), .DEPTH(IP_BUF)) u_win (
		.clk   (clk),
		.we    (win_we),
		.waddr (p[WIN_AW-1:0]),
		.wdata (frame_byte),
		.raddr (win_raddr),
		.rdata (win_rdata)
	);
endmodule
`default_nettype wire

/* hw/rtl/pffc_seq.sv */
// ----------------------------------------------------------------------------
// pffc_seq
// Lookup sequencer: key extraction, hash, way search and table update.
// ----------------------------------------------------------------------------
`default_nettype none
module pffc_seq
	import pffc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [2:0]        field_mode,
	input  wire logic [5:0]        payload_key_length,
	input  wire hdr_t              hdr,
	input  wire logic [7:0]        win_rdata,
	output logic [WIN_AW-1:0]      win_raddr,
	output logic                   busy,
	output logic                   clear,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output out_t                   res
);
	state_t state_q, state_d;

	logic [BUCKET_W-1:0] clr_q;
	logic [7:0]          off_q;
	logic [LEN_W-1:0]    len_q, i_q;
	logic                pay_q;
	logic [CAP_W-1:0]    cap_q;
	logic [BUCKET_W-1:0] hash_q, bucket_q;
	logic [WAYS-1:0]     row_q;
	logic [WAY_CW-1:0]   way_q;
	logic [KW_CW-1:0]    k_q;
	out_t                res_q;

	logic                pay;
	logic [7:0]          add, off, len;
	logic [8:0]          sum;
	logic                short_frame;
	logic [19:0]         field_hash;
	logic [ENT_W-1:0]    entry;
	logic [KADDR_W-1:0]  kaddr;
	logic [63:0]         key_rdata, cap_word;
	logic [31:0]         cnt_rdata, cnt_inc;
	logic [WAYS-1:0]     vrow_rdata;
	logic                mismatch, last_word, found;
	logic [WAY_CW-1:0]   free_way;
	logic                v_we, k_we, c_we;
	logic [WAYS-1:0]     v_wdata;
	logic [BUCKET_W-1:0] v_addr;
	logic [31:0]         c_wdata;

	assign pay = (field_mode == MODE_PAYLOAD) || (field_mode == MODE_UNUSED);

	always_comb begin
		case (hdr.proto)
			PROTO_ICMP: add = 8'd4;
			PROTO_TCP:  add = 8'd20;
			PROTO_UDP, PROTO_ESP, PROTO_IGMP: add = 8'd8;
			default:    add = 8'd0;
		endcase
		case (field_mode)
			MODE_SRC_PORT: begin off = 8'(hdr.hl);         len = 8'd2; end
			MODE_DST_PORT: begin off = 8'(hdr.hl) + 8'd2;  len = 8'd2; end
			MODE_IP_ID:    begin off = 8'd4;               len = 8'd2; end
			MODE_SEQ:      begin off = 8'(hdr.hl) + 8'd4;  len = 8'd4; end
			MODE_SRC_HOST: begin off = 8'd12;              len = 8'd4; end
			MODE_CHECKSUM: begin off = 8'd10;              len = 8'd2; end
			default: begin
				off = 8'(hdr.hl) + add;
				if (payload_key_length == 6'd0)
					len = 8'd1;
				else if (8'(payload_key_length) > 8'(MAX_KEY_BYTES))
					len = 8'(MAX_KEY_BYTES);
				else
					len = 8'(payload_key_length);
			end
		endcase
		sum = 9'(off) + 9'(len);
		short_frame = (16'(sum) > hdr.total_len) || (16'(sum) > hdr.received) ||
			(sum > 9'(IP_BUF));
	end

	assign field_hash = {4'd0, cap_q[15:0]};
	assign entry = ENT_W'(bucket_q) * ENT_W'(WAYS) + ENT_W'(way_q);
	assign kaddr = KADDR_W'(entry) * KADDR_W'(KEY_WORDS) + KADDR_W'(k_q);
	assign cap_word = cap_q[{k_q[KW_IW-1:0], 6'd0} +: 64];
	assign cnt_inc = (cnt_rdata == 32'hFFFF_FFFF) ? cnt_rdata : cnt_rdata + 32'd1;
	assign last_word = (8'(k_q) * 8'd8 + 8'd8) >= 8'(len_q);

	always_comb begin
		mismatch = 1'b0;
		for (int j = 0; j < 8; j++) begin
			if ((8'(k_q) * 8'd8 + 8'(j)) < 8'(len_q) &&
				key_rdata[j*8 +: 8] != cap_word[j*8 +: 8])
				mismatch = 1'b1;
		end
		found = 1'b0;
		free_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (!row_q[w]) begin
				found = 1'b1;
				free_way = WAY_CW'(w);
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		busy      = state_q != S_IDLE;
		clear     = 1'b0;
		res_valid = state_q == S_DONE;
		win_raddr = WIN_AW'(off_q + 8'(i_q));
		v_we      = 1'b0;
		v_addr    = bucket_q;
		v_wdata   = '0;
		k_we      = 1'b0;
		c_we      = 1'b0;
		c_wdata   = 32'd1;
		case (state_q)
			S_CLR: begin
				v_we   = 1'b1;
				v_addr = clr_q;
				if (clr_q == BUCKET_W'(BUCKETS - 1))
					state_d = S_IDLE;
			end
			S_IDLE: if (start) state_d = S_CALC;
			S_CALC: state_d = short_frame ? S_DONE : S_KADDR;
			S_KADDR: state_d = S_KDATA;
			S_KDATA: state_d = (i_q + LEN_W'(1) == len_q) ? S_HASH : S_KADDR;
			S_HASH: state_d = S_VADDR;
			S_VADDR: state_d = S_VDATA;
			S_VDATA: state_d = S_WAY;
			S_WAY: begin
				if (way_q == WAY_CW'(WAYS))
					state_d = S_MISS;
				else if (row_q[way_q[WAY_CW-1:0] % WAYS])
					state_d = S_CADDR;
			end
			S_CADDR: state_d = S_CDATA;
			S_CDATA: begin
				if (mismatch)
					state_d = S_WAY;
				else if (last_word)
					state_d = S_NADDR;
				else
					state_d = S_CADDR;
			end
			S_NADDR: state_d = S_NDATA;
			S_NDATA: begin
				c_we    = 1'b1;
				c_wdata = cnt_inc;
				state_d = S_DONE;
			end
			S_MISS: begin
				if (found) begin
					v_we    = 1'b1;
					v_wdata = row_q | (WAYS'(1) << free_way);
					state_d = S_INS;
				end else begin
					state_d = S_DONE;
				end
			end
			S_INS: begin
				k_we = 1'b1;
				if (k_q == '0)
					c_we = 1'b1;
				if (k_q == KW_CW'(KEY_WORDS - 1))
					state_d = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					clear   = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR)
				clr_q <= clr_q + BUCKET_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_CALC: begin
				off_q <= off;
				len_q <= LEN_W'(len);
				pay_q <= pay;
				i_q   <= '0;
				hash_q <= '0;
				cap_q <= '0;
				res_q <= '{status: ST_SHORT, occurrence_count: 32'd0, bucket_index: 10'd0};
			end
			S_KDATA: begin
				cap_q[{i_q[CAP_IW-1:0], 3'd0} +: 8] <= win_rdata;
				hash_q <= hash_q ^ (BUCKET_W'(win_rdata) << i_q);
				i_q    <= i_q + LEN_W'(1);
			end
			S_HASH: begin
				bucket_q <= pay_q ? hash_q : field_hash[BUCKET_W-1:0];
				way_q    <= '0;
				k_q      <= '0;
			end
			S_VDATA: row_q <= vrow_rdata;
			S_WAY: begin
				k_q <= '0;
				if (way_q != WAY_CW'(WAYS) && !row_q[way_q[WAY_CW-1:0] % WAYS])
					way_q <= way_q + WAY_CW'(1);
			end
			S_CDATA: begin
				if (mismatch)
					way_q <= way_q + WAY_CW'(1);
				else
					k_q <= k_q + KW_CW'(1);
			end
			S_NDATA: begin
				res_q.status           <= ST_EXIST;
				res_q.occurrence_count <= cnt_inc;
				res_q.bucket_index     <= 10'(bucket_q);
			end
			S_MISS: begin
				way_q <= free_way;
				k_q   <= '0;
				res_q.bucket_index <= 10'(bucket_q);
				res_q.status       <= found ? ST_NEW : ST_FULL;
				res_q.occurrence_count <= found ? 32'd1 : 32'd0;
			end
			S_INS: k_q <= k_q + KW_CW'(1);
			default: ;
		endcase
	end

	assign res = res_q;

	pffc_ram #(.WIDTH(WAYS), .DEPTH(BUCKETS)) u_valid (
		.clk(clk), .we(v_we), .waddr(v_addr), .wdata(v_wdata),
		.raddr(bucket_q), .rdata(vrow_rdata)
	);

	pffc_ram #(.WIDTH(64), .DEPTH(BUCKETS * WAYS * KEY_WORDS)) u_key (
		.clk(clk), .we(k_we), .waddr(kaddr), .wdata(cap_word),
		.raddr(kaddr), .rdata(key_rdata)
	);

	pffc_ram #(.WIDTH(32), .DEPTH(BUCKETS * WAYS)) u_count (
		.clk(clk), .we(c_we), .waddr(entry), .wdata(c_wdata),
		.raddr(entry), .rdata(cnt_rdata)
	);
endmodule
`default_nettype wire

/* hw/rtl/packet_field_frequency_counter_unit.sv */
// Packet field frequency counter. Frame bytes are taken one per cycle while the
// sequencer is idle; the byte that ends a frame starts the lookup sequencer,
// which holds stall high until its single result is handed to the output
// register. A short frame goes from the length check straight to the result.
// Otherwise the end-of-frame work is the length check, key extraction (L key
// bytes, one window RAM read each) and the valid row read, then a visit of the
// ways in turn with a compare of the key words (at most ceil(L/8)) for an
// occupied way, then a count update, an insertion or a full-bucket result,
// and last the hand-over of the result, which waits while the output
// is stalled. After reset a clearing pass over all BUCKETS rows (1024) of the
// valid RAM runs before the first byte is taken.
// ----------------------------------------------------------------------------
// packet_field_frequency_counter_unit
// Top level: APB registers, frame tracker, lookup sequencer, output register.
// ----------------------------------------------------------------------------
`default_nettype none
module packet_field_frequency_counter_unit
	import pffc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_t         in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_t             out_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic [2:0]        mode_q;
	logic [5:0]        plen_q;
	logic              accept, busy, clear, res_valid, res_ready;
	logic              out_valid_q;
	out_t              out_q, res;
	hdr_t              hdr;
	logic [7:0]        win_rdata;
	logic [WIN_AW-1:0] win_raddr;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_KEY_LENGTH) ? {26'd0, plen_q} : {29'd0, mode_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 3'd0;
			plen_q <= 6'd32;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_FIELD_MODE)
				mode_q <= pwdata[2:0];
			else
				plen_q <= pwdata[5:0];
		end
	end

	assign in_stall = busy;
	assign accept   = in_valid && !busy;

	pffc_hdr u_hdr (
		.clk(clk), .arst_n(arst_n), .accept(accept), .frame_byte(in_data.frame_byte),
		.clear(clear), .win_raddr(win_raddr), .win_rdata(win_rdata), .hdr(hdr)
	);

	pffc_seq u_seq (
		.clk(clk), .arst_n(arst_n), .start(accept && in_data.frame_end),
		.field_mode(mode_q), .payload_key_length(plen_q), .hdr(hdr),
		.win_rdata(win_rdata), .win_raddr(win_raddr), .busy(busy), .clear(clear),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_ready)
			out_valid_q <= res_valid;
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready)
			out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule
`default_nettype wire

/* dv/tb_packet_field_frequency_counter_unit.sv */
// ----------------------------------------------------------------------------
// tb_packet_field_frequency_counter_unit
// Streams Ethernet frames byte by byte into the counter, changes the key mode
// and payload key length over the APB port between phases, and checks every
// result transfer against a behavioral model of the key lookup table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_packet_field_frequency_counter_unit
	import pffc_pkg::*;
();

	localparam int IDLE_LIMIT = 20000;
	localparam out_t SHORT_RES = '{status: ST_SHORT, occurrence_count: '0, bucket_index: '0};

	typedef struct {
		logic [2:0] mode;
		logic [5:0] klen;
		logic [3:0] hl;
		logic [7:0] proto;
		int         ip_len;
		int         tot;
		logic [7:0] flavor;
		bit         rnd;
		bit         typed;
	} frame_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_t         in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_t        out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	packet_field_frequency_counter_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// model state
	logic [2:0]   cur_mode;
	logic [5:0]   cur_klen;
	logic [15:0]  byte_pos;
	logic [5:0]   hdr_len;
	logic [7:0]   proto_num;
	logic [15:0]  total_len;
	logic [7:0]   ip_win [IP_BUF];
	bit           way_used [BUCKETS*WAYS];
	logic [255:0] way_key [BUCKETS*WAYS];
	logic [31:0]  way_count [BUCKETS*WAYS];

	out_t expected_q [$];
	int   mismatches = 0;
	int   idle_cycles = 0;
	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	int   phase_bytes;

	function automatic void clear_frame();
		byte_pos = '0;
		hdr_len = '0;
		proto_num = '0;
		total_len = '0;
		foreach (ip_win[i]) ip_win[i] = '0;
	endfunction

	function automatic bit count_frame_byte(in_t d, output out_t res);
		int p, rcv, add, off, len, b, e;
		logic [255:0] key;
		logic [19:0] hsh;
		bit same;
		res = SHORT_RES;
		if (byte_pos >= 14) begin
			p = byte_pos - 14;
			if (p < IP_BUF) ip_win[p] = d.frame_byte;
			case (p)
				0: hdr_len = {d.frame_byte[3:0], 2'b00};
				2: total_len[15:8] = d.frame_byte;
				3: total_len[7:0] = d.frame_byte;
				9: proto_num = d.frame_byte;
				default: ;
			endcase
		end
		if (byte_pos != 16'hffff) byte_pos++;
		if (!d.frame_end) return 0;
		rcv = byte_pos > 14 ? byte_pos - 14 : 0;
		case (proto_num)
			PROTO_ICMP: add = 4;
			PROTO_TCP: add = 20;
			PROTO_UDP, PROTO_ESP, PROTO_IGMP: add = 8;
			default: add = 0;
		endcase
		case (cur_mode)
			MODE_SRC_PORT: begin off = hdr_len; len = 2; end
			MODE_DST_PORT: begin off = hdr_len + 2; len = 2; end
			MODE_IP_ID: begin off = 4; len = 2; end
			MODE_SEQ: begin off = hdr_len + 4; len = 4; end
			MODE_SRC_HOST: begin off = 12; len = 4; end
			MODE_CHECKSUM: begin off = 10; len = 2; end
			default: begin
				off = hdr_len + add;
				len = cur_klen == 0 ? 1 : (cur_klen > MAX_KEY_BYTES ? MAX_KEY_BYTES : cur_klen);
			end
		endcase
		if (off + len > total_len || off + len > rcv || off + len > IP_BUF) begin
			clear_frame();
			return 1;
		end
		key = '0;
		for (int i = 0; i < len; i++) key[i*8 +: 8] = ip_win[off + i];
		clear_frame();
		if (cur_mode inside {MODE_SRC_PORT, MODE_DST_PORT, MODE_IP_ID, MODE_SEQ,
				MODE_SRC_HOST, MODE_CHECKSUM}) begin
			hsh = {4'b0, key[15:8], key[7:0]};
		end else begin
			hsh = '0;
			for (int i = 0; i < len && i < 20; i++) hsh ^= 20'(key[i*8 +: 8]) << i;
		end
		b = hsh[9:0];
		res.bucket_index = hsh[9:0];
		for (int w = 0; w < WAYS; w++) begin
			e = b * WAYS + w;
			if (!way_used[e]) continue;
			same = 1;
			for (int i = 0; i < len; i++)
				if (way_key[e][i*8 +: 8] != key[i*8 +: 8]) same = 0;
			if (same) begin
				if (way_count[e] != 32'hffff_ffff) way_count[e]++;
				res.status = ST_EXIST;
				res.occurrence_count = way_count[e];
				return 1;
			end
		end
		for (int w = 0; w < WAYS; w++) begin
			e = b * WAYS + w;
			if (!way_used[e]) begin
				way_used[e] = 1;
				way_key[e] = key;
				way_count[e] = 1;
				res.status = ST_NEW;
				res.occurrence_count = 1;
				return 1;
			end
		end
		res.status = ST_FULL;
		return 1;
	endfunction

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_idle_pct);
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result transfer: %p", out_data);
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				if (out_data.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, out_data.status);
					mismatches++;
				end
				if (out_data.occurrence_count !== want.occurrence_count) begin
					$error("occurrence_count: expected %0d, got %0d",
						want.occurrence_count, out_data.occurrence_count);
					mismatches++;
				end
				if (out_data.bucket_index !== want.bucket_index) begin
					$error("bucket_index: expected %0d, got %0d",
						want.bucket_index, out_data.bucket_index);
					mismatches++;
				end
			end
		end
	end

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic apb_write(logic reg_idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_idx == REG_FIELD_MODE) cur_mode = val[2:0];
		else cur_klen = val[5:0];
	endtask

	task automatic set_config(logic [2:0] mode, logic [5:0] klen);
		wait_drained();
		apb_write(REG_FIELD_MODE, {29'b0, mode});
		apb_write(REG_KEY_LENGTH, {26'b0, klen});
	endtask

	function automatic logic [7:0] frame_byte_at(frame_t fr, int k);
		int p;
		if (k < 14 || fr.rnd) return 8'($urandom);
		p = k - 14;
		case (p)
			0: return {4'h4, fr.hl};
			2: return 8'(fr.tot >> 8);
			3: return 8'(fr.tot);
			4, 10: return 8'h33;
			5, 11: return {fr.flavor[5:0], 2'b01};
			9: return fr.proto;
			12: return 8'h0a;
			13: return 8'h01;
			14: return fr.flavor;
			default: return fr.flavor * 8'h1d ^ 8'(p);
		endcase
	endfunction

	task automatic send_frame(frame_t fr);
		in_t d;
		out_t r;
		int n;
		n = 14 + fr.ip_len;
		for (int k = 0; k < n; k++) begin
			d.frame_byte = frame_byte_at(fr, k);
			d.frame_end = (k == n - 1);
			in_valid <= 1'b1;
			in_data <= d;
			do @(posedge clk); while (in_stall);
			phase_bytes++;
			if (count_frame_byte(d, r)) expected_q.push_back(fr.typed ? SHORT_RES : r);
			while ($urandom_range(99) < tx_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
	endtask

	function automatic frame_t random_frame();
		frame_t fr;
		int add, len;
		fr.mode = cur_mode;
		fr.klen = cur_klen;
		fr.typed = 0;
		fr.flavor = 8'($urandom_range(0, 7));
		if ($urandom_range(99) < 20) begin
			fr.rnd = 1;
			fr.hl = 4'($urandom);
			fr.proto = 8'($urandom);
			fr.ip_len = $urandom_range(0, 80) - 13;
			fr.tot = 0;
			return fr;
		end
		fr.rnd = ($urandom_range(99) < 15);
		fr.hl = 4'($urandom_range(5, 7));
		case ($urandom_range(0, 5))
			0: begin fr.proto = PROTO_ICMP; add = 4; end
			1: begin fr.proto = PROTO_TCP; add = 20; end
			2: begin fr.proto = PROTO_UDP; add = 8; end
			3: begin fr.proto = PROTO_ESP; add = 8; end
			4: begin fr.proto = PROTO_IGMP; add = 8; end
			default: begin fr.proto = 8'h2f; add = 0; end
		endcase
		len = (cur_mode == MODE_PAYLOAD || cur_mode == MODE_UNUSED) ?
			add + (cur_klen > 32 ? 32 : cur_klen) : 8;
		fr.tot = fr.hl * 4 + len + $urandom_range(0, 4) - ($urandom_range(99) < 10 ? 5 : 0);
		fr.ip_len = fr.tot + $urandom_range(0, 3);
		return fr;
	endfunction

	frame_t directed [] = '{
		'{MODE_PAYLOAD, 6'd32, 4'd5, PROTO_ICMP, -13, 0, 8'd0, 0, 1},
		'{MODE_PAYLOAD, 6'd32, 4'd5, PROTO_ICMP, 0, 0, 8'd0, 0, 1},
		'{MODE_PAYLOAD, 6'd32, 4'd5, PROTO_ICMP, 3, 60, 8'd0, 0, 1},
		'{MODE_PAYLOAD, 6'd32, 4'd5, PROTO_ICMP, 60, 60, 8'd1, 0, 0},
		'{MODE_PAYLOAD, 6'd32, 4'd5, PROTO_ICMP, 60, 60, 8'd1, 0, 0},
		'{MODE_PAYLOAD, 6'd32, 4'd5, PROTO_TCP, 71, 71, 8'd1, 0, 1},
		'{MODE_PAYLOAD, 6'd32, 4'd5, PROTO_TCP, 50, 200, 8'd1, 0, 1},
		'{MODE_PAYLOAD, 6'd32, 4'd5, PROTO_TCP, 72, 72, 8'd2, 0, 0},
		'{MODE_PAYLOAD, 6'd32, 4'd15, PROTO_TCP, 120, 112, 8'd3, 0, 0},
		'{MODE_PAYLOAD, 6'd1, 4'd0, 8'h55, 20, 20, 8'd4, 0, 0},
		'{MODE_PAYLOAD, 6'd1, 4'd5, PROTO_UDP, 30, 30, 8'd4, 0, 0},
		'{MODE_PAYLOAD, 6'd0, 4'd5, PROTO_ESP, 30, 30, 8'd4, 0, 0},
		'{MODE_PAYLOAD, 6'd63, 4'd5, PROTO_IGMP, 70, 70, 8'd5, 0, 0},
		'{MODE_SRC_PORT, 6'd32, 4'd5, PROTO_TCP, 40, 40, 8'd1, 0, 0},
		'{MODE_DST_PORT, 6'd32, 4'd5, PROTO_TCP, 40, 40, 8'd1, 0, 0},
		'{MODE_IP_ID, 6'd32, 4'd5, PROTO_TCP, 40, 40, 8'd1, 0, 0},
		'{MODE_SEQ, 6'd32, 4'd5, PROTO_TCP, 40, 40, 8'd1, 0, 0},
		'{MODE_SRC_HOST, 6'd32, 4'd5, PROTO_TCP, 40, 40, 8'd1, 0, 0},
		'{MODE_CHECKSUM, 6'd32, 4'd5, PROTO_TCP, 40, 40, 8'd1, 0, 0},
		'{MODE_CHECKSUM, 6'd32, 4'd5, PROTO_TCP, 11, 40, 8'd1, 0, 1},
		'{MODE_UNUSED, 6'd4, 4'd5, PROTO_UDP, 40, 40, 8'd6, 0, 0},
		'{MODE_UNUSED, 6'd4, 4'd5, PROTO_UDP, 130, 40, 8'd6, 0, 0}
	};

	initial begin
		frame_t fr;
		cur_mode = MODE_PAYLOAD;
		cur_klen = 6'd32;
		clear_frame();
		foreach (way_used[i]) way_used[i] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		tx_idle_pct = 35;
		rx_idle_pct = 84;
		set_config(MODE_PAYLOAD, 6'd32);
		foreach (directed[i]) begin
			if (directed[i].mode != cur_mode || directed[i].klen != cur_klen)
				set_config(directed[i].mode, directed[i].klen);
			send_frame(directed[i]);
		end
		for (int ph = 0; ph < 3; ph++) begin
			tx_idle_pct = ph == 0 ? 35 : (ph == 1 ? 84 : 0);
			rx_idle_pct = ph == 0 ? 84 : (ph == 1 ? 35 : 0);
			phase_bytes = 0;
			for (int nf = 0; phase_bytes < 100; nf++) begin
				if (nf % 8 == 0)
					set_config(3'($urandom_range(0, 7)), $urandom_range(99) < 20 ?
						6'($urandom) : 6'($urandom_range(1, 8)));
				fr = random_frame();
				send_frame(fr);
			end
		end
		wait_drained();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/pffc_pkg.sv
hw/rtl/pffc_ram.sv
hw/rtl/pffc_hdr.sv
hw/rtl/pffc_seq.sv
hw/rtl/packet_field_frequency_counter_unit.sv
dv/tb_packet_field_frequency_counter_unit.sv
